@@ sv/ffcmf_pkg.sv @@
`timescale 1ns / 1ps

package ffcmf_pkg;

  localparam int unsigned FRAMES = 5;
  localparam int unsigned SLOT_W = 3;

  localparam logic [SLOT_W-1:0] FIRST_SLOT   = '0;
  localparam logic [SLOT_W-1:0] CONTROL_SLOT = 3'd1;
  localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(FRAMES - 1);

  localparam logic [7:0] SYNC_MARK    = 8'h40;
  localparam logic [7:0] PAYLOAD_MARK = 8'h80;

  // byte positions within a frame
  localparam logic [1:0] BYTE_SYNC = 2'd0;
  localparam logic [1:0] BYTE_R1   = 2'd1;
  localparam logic [1:0] BYTE_R2   = 2'd2;
  localparam logic [1:0] BYTE_SH   = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       radio1_present;
    logic [7:0] radio1_data;
    logic       radio2_present;
    logic [7:0] radio2_data;
    logic       shared_present;
    logic [7:0] shared_data;
    logic       inside_command;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] frame;
    logic [1:0]        idx;
    logic              is_data;
    logic              last;
  } pos_t;

endpackage

@@ sv/ffcmf_in_if.sv @@
`timescale 1ns / 1ps

interface ffcmf_in_if;
  logic       valid;
  logic       ready;
  logic       radio1_present;
  logic [7:0] radio1_data;
  logic       radio2_present;
  logic [7:0] radio2_data;
  logic       shared_present;
  logic [7:0] shared_data;
  logic       inside_command;

  modport source (
    output valid, radio1_present, radio1_data, radio2_present, radio2_data,
           shared_present, shared_data, inside_command,
    input  ready
  );

  modport sink (
    input  valid, radio1_present, radio1_data, radio2_present, radio2_data,
           shared_present, shared_data, inside_command,
    output ready
  );
endinterface

@@ sv/ffcmf_out_if.sv @@
`timescale 1ns / 1ps

interface ffcmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] frame_slot;
  logic       last_of_run;

  modport source (
    output valid, out_byte, frame_slot, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_byte, frame_slot, last_of_run,
    output ready
  );
endinterface

@@ sv/ffcmf_byte_gen.sv @@
`timescale 1ns / 1ps

module ffcmf_byte_gen (
  input  ffcmf_pkg::item_t item,
  input  ffcmf_pkg::pos_t  pos,
  output logic [7:0]       byte_out
);

  logic       marker;
  logic       sh_valid;
  logic [7:0] sync;

  always_comb begin
    marker   = (pos.frame != ffcmf_pkg::FIRST_SLOT);
    sh_valid = item.shared_present &&
               ((pos.frame != ffcmf_pkg::CONTROL_SLOT) || item.inside_command);
    if (pos.is_data) begin
      sync = {1'b0, marker,
              item.radio1_present, item.radio2_present, sh_valid,
              item.radio1_present & item.radio1_data[7],
              item.radio2_present & item.radio2_data[7],
              item.shared_present & item.shared_data[7]};
    end else begin
      // held empty frame: marker only
      sync = {1'b0, marker, 6'b0};
    end

    unique case (pos.idx)
      ffcmf_pkg::BYTE_SYNC: byte_out = sync;
      ffcmf_pkg::BYTE_R1: byte_out = ffcmf_pkg::PAYLOAD_MARK |
          ((pos.is_data && item.radio1_present) ? item.radio1_data : 8'h00);
      ffcmf_pkg::BYTE_R2: byte_out = ffcmf_pkg::PAYLOAD_MARK |
          ((pos.is_data && item.radio2_present) ? item.radio2_data : 8'h00);
      ffcmf_pkg::BYTE_SH: byte_out = ffcmf_pkg::PAYLOAD_MARK |
          ((pos.is_data && item.shared_present) ? item.shared_data : 8'h00);
      default: byte_out = ffcmf_pkg::PAYLOAD_MARK;
    endcase
  end

endmodule

@@ sv/ffcmf_seq.sv @@
`timescale 1ns / 1ps

module ffcmf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            any_present,
  input  logic            step,
  output logic            in_ready,
  output logic            emit,
  output ffcmf_pkg::pos_t pos
);

  ffcmf_pkg::state_t state, state_next;
  logic [ffcmf_pkg::SLOT_W-1:0] slot, slot_next;
  logic [ffcmf_pkg::SLOT_W-1:0] held, held_next;
  logic [ffcmf_pkg::SLOT_W-1:0] cur_frame, cur_frame_next;
  logic [ffcmf_pkg::SLOT_W-1:0] data_slot, data_slot_next;
  logic [1:0]                   byte_idx, byte_idx_next;
  logic                         accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffcmf_pkg::ST_IDLE;
      slot      <= '0;
      held      <= '0;
      cur_frame <= '0;
      data_slot <= '0;
      byte_idx  <= '0;
    end else begin
      state     <= state_next;
      slot      <= slot_next;
      held      <= held_next;
      cur_frame <= cur_frame_next;
      data_slot <= data_slot_next;
      byte_idx  <= byte_idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    slot_next      = slot;
    held_next      = held;
    cur_frame_next = cur_frame;
    data_slot_next = data_slot;
    byte_idx_next  = byte_idx;

    in_ready    = (state == ffcmf_pkg::ST_IDLE);
    emit        = (state == ffcmf_pkg::ST_EMIT);
    accept      = in_valid && in_ready;
    pos.frame   = cur_frame;
    pos.idx     = byte_idx;
    pos.is_data = (cur_frame == data_slot);
    pos.last    = pos.is_data && (byte_idx == ffcmf_pkg::BYTE_SH);

    unique case (state)
      ffcmf_pkg::ST_IDLE: begin
        if (accept) begin
          if (any_present) begin
            // replay held empty frames first, then the data frame
            state_next     = ffcmf_pkg::ST_EMIT;
            cur_frame_next = slot - held;
            data_slot_next = slot;
            byte_idx_next  = ffcmf_pkg::BYTE_SYNC;
            held_next      = '0;
          end else begin
            held_next = held + 3'd1;
          end
          if (slot == ffcmf_pkg::LAST_SLOT) begin
            slot_next = ffcmf_pkg::FIRST_SLOT;
            held_next = '0;
          end else begin
            slot_next = slot + 3'd1;
          end
        end
      end
      ffcmf_pkg::ST_EMIT: begin
        if (step) begin
          byte_idx_next = byte_idx + 2'd1;
          if (byte_idx == ffcmf_pkg::BYTE_SH) begin
            cur_frame_next = cur_frame + 3'd1;
          end
          if (pos.last) begin
            state_next = ffcmf_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = ffcmf_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ sv/five_frame_channel_mux_framer_unit.sv @@
`timescale 1ns / 1ps

// five-frame channel multiplexer framer
//
// in_ch takes one beat per frame slot (flags, control, keyer, fsk1, fsk2 in
// turn). each beat offers optional radio 1, radio 2 and shared channel bytes.
// out_ch gives the framed byte stream, one byte per beat, tagged with its
// frame slot; last_of_run marks the final byte caused by an input beat.
// a beat with no byte present gives no output and is held as an empty frame,
// replayed ahead of the next frame with data in the same sequence; empty
// frames still held at the end of the sequence are dropped.
// an accepted beat is registered into the item and sequencer registers,
// then each byte of the run into the out_ch register. no new beat is taken
// until the run (held empty frames plus the data frame) is out, byte by byte
// from the single byte generator the sequencer steps; an empty beat is taken alone.
// in_ch.ready is low while a frame run is being emitted.
// when out_ch.ready is low with a byte valid, the output register holds and the sequencer waits.
// reset (rst, synchronous) clears the slot counter, the held-frame count and
// the output valid flag.

module five_frame_channel_mux_framer_unit (
  input logic         clk,
  input logic         rst,
  ffcmf_in_if.sink    in_ch,
  ffcmf_out_if.source out_ch
);

  ffcmf_pkg::item_t item;
  ffcmf_pkg::pos_t  pos;
  logic             any_present;
  logic             emit;
  logic             load;
  logic [7:0]       gen_byte;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic [2:0]       frame_slot;
  logic             last_of_run;

  assign any_present = in_ch.radio1_present | in_ch.radio2_present |
                       in_ch.shared_present;
  assign load        = !out_valid || out_ch.ready;

  ffcmf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .any_present (any_present),
    .step        (load),
    .in_ready    (in_ch.ready),
    .emit        (emit),
    .pos         (pos)
  );

  ffcmf_byte_gen u_gen (
    .item     (item),
    .pos      (pos),
    .byte_out (gen_byte)
  );

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.radio1_present <= in_ch.radio1_present;
      item.radio1_data    <= in_ch.radio1_data;
      item.radio2_present <= in_ch.radio2_present;
      item.radio2_data    <= in_ch.radio2_data;
      item.shared_present <= in_ch.shared_present;
      item.shared_data    <= in_ch.shared_data;
      item.inside_command <= in_ch.inside_command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_byte    <= gen_byte;
      frame_slot  <= pos.frame;
      last_of_run <= pos.last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.frame_slot  = frame_slot;
  assign out_ch.last_of_run = last_of_run;

  // an empty beat never makes output appear
  a_empty_no_output: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && !any_present && !out_valid |=> !out_valid)
    else $error("output from an empty input beat");

  // sync bytes carry the marker in every slot but the first
  a_sync_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_byte[7] |-> (out_byte[6] == (frame_slot != 3'd0)))
    else $error("sync marker does not match frame slot");

  // the closing byte of a run is always a payload byte
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> out_byte[7])
    else $error("last byte of run is not a payload byte");

  // no new input while a run is still being generated
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    emit |-> !in_ch.ready)
    else $error("input taken during frame run");

endmodule
